// ===== hdl/sapsum_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted alternate-position sum block.
// No dependencies.
package sapsum_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } sapsum_state_t;

    // One slot of the sorted chain as seen by its neighbors.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } cell_data_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hdl/sapsum_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the key input and the result output.
// Depends on sapsum_pkg.
interface sapsum_in_if
    import sapsum_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key_value;
    logic                    last_item;

    modport source (output valid, key_value, last_item, input ready);
    modport sink   (input valid, key_value, last_item, output ready);
endinterface

interface sapsum_out_if
    import sapsum_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] even_position_sum;
    logic                    capacity_exceeded;

    modport source (output valid, even_position_sum, capacity_exceeded, input ready);
    modport sink   (input valid, even_position_sum, capacity_exceeded, output ready);
endinterface

// ===== hdl/sapsum_cell.sv =====
`timescale 1ns / 1ps
// One slot of the descending insertion chain.
// Depends on sapsum_pkg.
module sapsum_cell
    import sapsum_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic signed [KEY_W-1:0] new_key,
    input  cell_data_t              prev,
    input  logic                    prev_greater,
    input  cell_data_t              next,
    output cell_data_t              cur,
    output logic                    greater
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;

    // New key belongs ahead of this slot (strict: equal keys stay in front).
    assign greater = !valid_reg || (new_key > $signed(key_reg));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctrl.shift)
        begin
            valid_next = next.valid;
            key_next   = next.key;
        end
        else if (ctrl.insert)
        begin
            if (prev_greater)
            begin
                valid_next = prev.valid;
                key_next   = prev.key;
            end
            else if (greater)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;

endmodule

// ===== hdl/sorted_alternate_position_sum.sv =====
`timescale 1ns / 1ps
// Sorted alternate-position sum: top level, chain of MAX_KEYS insertion cells.
// Depends on sapsum_pkg, sapsum_if (stream interfaces) and sapsum_cell.
//
// Usage:
//  - keys: one signed key per transaction; last_item closes the set.
//    Keys stream in at one per cycle while loading; each is placed into the
//    descending chain in the cycle it is accepted (all cells compare in parallel).
//  - A key arriving while all MAX_KEYS cells hold data is dropped and
//    flags capacity_exceeded for the set; a dropped last key still closes it.
//  - After the last key the chain shifts toward the head one cell per
//    cycle while an accumulator adds every other key. keys.ready is low
//    during that drain.
//  - result: one transaction per set, held in an output register. The
//    drain only finishes once that register is free, so a stalled
//    receiver holds the block in drain (and holds keys.ready low).
//  - Sustained rate: one key per cycle within a set; each set then needs
//    a drain through the single shared accumulator at the chain head,
//    during which no keys are taken.
//  - Reset (rst_n low, async) empties the chain, clears the drop flag and
//    the output valid; key contents are left as they are.
module sorted_alternate_position_sum
    import sapsum_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sapsum_in_if.sink           keys,
    sapsum_out_if.source        result
);

    sapsum_state_t    state_reg, state_next;
    logic             dropped_reg, dropped_next;
    logic             even_reg, even_next;
    logic [KEY_W-1:0] acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] out_sum_reg, out_sum_next;
    logic             out_flag_reg, out_flag_next;

    cell_ctrl_t       ctrl;
    cell_data_t       cell_q  [MAX_KEYS];
    logic             cell_gt [MAX_KEYS];
    logic [MAX_KEYS-1:0] cell_valid;

    logic             accept;
    logic             full;
    logic             out_free;
    logic             finish;

    // ------------------------------------------------------------------
    // Cell chain: head is index 0 (largest key). Insertion moves data
    // toward the tail, draining moves it toward the head.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_cell
        cell_data_t prev_d, next_d;
        logic       prev_g;

        if (i == 0)
        begin : g_head
            assign prev_d = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_d = cell_q[i-1];
            assign prev_g = cell_gt[i-1];
        end

        if (i == MAX_KEYS - 1)
        begin : g_tail
            assign next_d = '0;
        end
        else
        begin : g_inner
            assign next_d = cell_q[i+1];
        end

        sapsum_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .new_key      (keys.key_value),
            .prev         (prev_d),
            .prev_greater (prev_g),
            .next         (next_d),
            .cur          (cell_q[i]),
            .greater      (cell_gt[i])
        );

        assign cell_valid[i] = cell_q[i].valid;
    end

    assign full     = cell_valid[MAX_KEYS-1];
    assign accept   = keys.valid && keys.ready;
    assign out_free = !out_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (accept && keys.last_item)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!cell_valid[0] && out_free)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Control: outputs
    always_comb
    begin
        keys.ready  = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        finish      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                // ready is high throughout load, so valid alone marks a transaction
                keys.ready  = 1'b1;
                ctrl.insert = keys.valid && !full;
            end
            ST_DRAIN:
            begin
                ctrl.shift = cell_valid[0];
                finish     = !cell_valid[0] && out_free;
            end
            default:
            begin
                keys.ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: drop flag, even-position accumulator, output register
    // ------------------------------------------------------------------
    always_comb
    begin
        dropped_next   = dropped_reg;
        even_next      = even_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_sum_next   = out_sum_reg;
        out_flag_next  = out_flag_reg;

        if (accept)
        begin
            dropped_next = dropped_reg || full;
            if (keys.last_item)
            begin
                even_next = 1'b1;
                acc_next  = '0;
            end
        end

        if (ctrl.shift)
        begin
            if (even_reg)
                acc_next = acc_reg + cell_q[0].key;
            even_next = !even_reg;
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = acc_reg;
            out_flag_next  = dropped_reg;
            dropped_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        even_reg     <= even_next;
        acc_reg      <= acc_next;
        out_sum_reg  <= out_sum_next;
        out_flag_reg <= out_flag_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.even_position_sum = out_sum_reg;
    assign result.capacity_exceeded = out_flag_reg;

`ifndef SYNTHESIS
    // Occupied cells always form a contiguous run starting at the head.
    a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("sorted chain has a hole");

    // The two leading keys stay in descending order.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid[1] && state_reg == ST_LOAD) |->
            ($signed(cell_q[0].key) >= $signed(cell_q[1].key)))
        else $error("chain head out of order");

    // Closing a set stops key intake for the drain.
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && keys.last_item) |=> !keys.ready)
        else $error("keys accepted during drain");

    // A result is only posted when the chain has fully drained.
    a_post_empty: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (cell_valid == '0))
        else $error("result posted before chain empty");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_alternate_position_sum.
// Depends on sapsum_pkg, sapsum_if and the block's RTL; reads no files.
module testbench;
    import sapsum_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    // Allow margin on top of the drain of a full chain.
    localparam int DRAIN_TAIL  = MAX_KEYS + 16;
    localparam int CYCLE_LIMIT = 400000;

    // One expected result transaction.
    typedef struct packed {
        logic signed [KEY_W-1:0] sum;
        logic                    dropped;
    } set_result_t;

    // Mirrors the descending store and predicts the per-set result.
    class even_sum_scoreboard;
        logic signed [KEY_W-1:0] held_keys[$];
        logic                    set_dropped;
        set_result_t             expected_sums[$];
        int unsigned             errors;

        function new();
            set_dropped = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        // Called for every accepted key transaction.
        function void note_key(logic signed [KEY_W-1:0] key, logic closes_set);
            int unsigned             pos;
            logic signed [KEY_W-1:0] acc;
            set_result_t             res;
            if (held_keys.size() >= MAX_KEYS) begin
                set_dropped = 1'b1;
            end
            else begin
                // equal keys go after the ones already held; sum is unaffected
                pos = 0;
                while (pos < held_keys.size() && held_keys[pos] >= key)
                    pos++;
                held_keys.insert(pos, key);
            end
            if (closes_set) begin
                acc = '0;
                for (int i = 0; i < held_keys.size(); i += 2)
                    acc += held_keys[i];     // wraps at 32 bits
                res.sum     = acc;
                res.dropped = set_dropped;
                expected_sums.push_back(res);
                held_keys.delete();
                set_dropped = 1'b0;
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic signed [KEY_W-1:0] sum, logic dropped);
            set_result_t exp_res;
            if (expected_sums.size() == 0) begin
                $error("unexpected result: even_position_sum %0d, capacity_exceeded %0b",
                       sum, dropped);
                errors++;
                return;
            end
            exp_res = expected_sums.pop_front();
            if (sum !== exp_res.sum) begin
                $error("even_position_sum mismatch: expected %0d, actual %0d",
                       exp_res.sum, sum);
                errors++;
            end
            if (dropped !== exp_res.dropped) begin
                $error("capacity_exceeded mismatch: expected %0b, actual %0b",
                       exp_res.dropped, dropped);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sapsum_in_if  keys_if ();
    sapsum_out_if result_if ();

    even_sum_scoreboard sum_board = new();

    int          send_idle_pct;   // chance in 100 that the sender idles a cycle
    int          recv_idle_pct;   // chance in 100 that the receiver stalls a cycle
    int unsigned items_sent;
    int unsigned cycle_count;

    sorted_alternate_position_sum i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_if),
        .result (result_if)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit; generous against the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge only.
    always @(negedge clk)
        result_if.ready = ($urandom_range(99) >= recv_idle_pct);

    // Monitor: both channels sampled at the rising edge, before the block's
    // registers update, so a transaction is seen exactly when it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (keys_if.valid && keys_if.ready)
                sum_board.note_key(keys_if.key_value, keys_if.last_item);
            if (result_if.valid && result_if.ready)
                sum_board.check_result(result_if.even_position_sum,
                                       result_if.capacity_exceeded);
        end
    end

    // Entered and left at a falling edge. valid drops after acceptance and is
    // raised again in the same step by the next call, via blocking writes, so
    // back-to-back transactions see valid high at every rising edge.
    task automatic send_key(input logic signed [KEY_W-1:0] key, input logic closes_set);
        while ($urandom_range(99) < send_idle_pct)
        begin
            keys_if.valid = 1'b0;
            @(negedge clk);
        end
        keys_if.valid     = 1'b1;
        keys_if.key_value = key;
        keys_if.last_item = closes_set;
        @(posedge clk);
        while (!keys_if.ready)
            @(posedge clk);
        @(negedge clk);
        keys_if.valid = 1'b0;
        items_sent++;
    endtask

    // Mix of full-range keys, a narrow band that forces duplicates, and extremes.
    function automatic logic signed [KEY_W-1:0] rand_key();
        logic signed [KEY_W-1:0] key;
        case ($urandom_range(3))
            0: key = KEY_W'(int'($urandom_range(8)) - 4);
            1:
            begin
                case ($urandom_range(3))
                    0: key = KEY_MAX;
                    1: key = KEY_MIN;
                    2: key = '0;
                    default: key = '1;
                endcase
            end
            default: key = $urandom;
        endcase
        return key;
    endfunction

    task automatic send_random_set(input int unsigned len);
        for (int unsigned i = 1; i <= len; i++)
            send_key(rand_key(), i == len);
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_for_results();
        while (sum_board.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly short sets; now and then one near the store's size that may fill or overrun it.
    task automatic run_phase(input int send_pct, input int recv_pct, input int unsigned budget);
        int unsigned stop_at;
        stop_at       = items_sent + budget;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(19) == 0)
                send_random_set($urandom_range(MAX_KEYS + 6, MAX_KEYS - 4));
            else
                send_random_set($urandom_range(10, 1));
            if ($urandom_range(24) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        keys_if.valid       = 1'b0;
        keys_if.key_value   = '0;
        keys_if.last_item   = 1'b0;
        send_idle_pct       = 19;
        recv_idle_pct       = 87;
        items_sent          = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: single-key sets at the extremes
        send_key(KEY_MAX, 1'b1);
        send_key(KEY_MIN, 1'b1);
        send_key('0, 1'b1);
        send_key('1, 1'b1);
        // max lands at the head, min at the odd slot
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MAX, 1'b1);
        // positive overflow: max + 5 wraps
        send_key(KEY_MAX, 1'b0);
        send_key(32'sd5, 1'b0);
        send_key(KEY_MAX, 1'b1);
        // negative overflow: min + min wraps to zero
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MIN, 1'b1);
        // duplicates interleaved
        send_key(32'sd3, 1'b0);
        send_key(-32'sd7, 1'b0);
        send_key(32'sd3, 1'b0);
        send_key(32'sd3, 1'b0);
        send_key(-32'sd7, 1'b1);
        // ascending arrival: every new key goes to the head
        send_key(32'sd1, 1'b0);
        send_key(32'sd2, 1'b0);
        send_key(32'sd4, 1'b0);
        send_key(32'sd8, 1'b1);

        // Store exactly full, then a closing key that is dropped, then a deep overrun
        send_random_set(MAX_KEYS);
        send_random_set(MAX_KEYS + 1);
        send_random_set(MAX_KEYS + 6);

        run_phase(19, 87, 600);
        run_phase(87, 19, 600);
        run_phase(0, 0, 550);

        // Drain whatever is still in flight, then watch for stray results.
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (sum_board.pending() != 0)
            $error("%0d expected results never arrived", sum_board.pending());
        if (sum_board.errors == 0 && sum_board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
